// File: hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file bssc_checker.sv.
// Needs nothing else; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check at the rising clock, off while reset is held.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error("%m: check failed");

// Implication that only applies while a result item is shown.
`define ASSERT_ON_OUT(lbl, clk_sig, rstn_sig, vld, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) vld |-> (prop)) \
		else $error("%m: result check failed");

`endif

// File: hw/rtl/bssc_pkg.sv
// bssc_pkg: types and constants of the motor start-up / speed controller.
// Used by the top level and by its port checker; depends on nothing.
package bssc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [2:0] REG_CURRENT_LIMIT = 3'd2;
	localparam logic [2:0] REG_ALIGN_CURRENT = 3'd3;
	localparam logic [2:0] REG_ALIGN_STEP    = 3'd4;
	localparam logic [2:0] REG_HOLD_TICKS    = 3'd5;
	localparam logic [2:0] REG_SPEED_SLEW    = 3'd6;
	localparam logic [2:0] REG_OFFSET_COUNT  = 3'd7;

	localparam int unsigned CFG_DATA_W = 18;

	// reset values of the registers
	localparam logic [15:0] RST_PROP_GAIN     = 16'd16777;
	localparam logic [15:0] RST_INTEG_GAIN    = 16'd8389;
	localparam logic [17:0] RST_CURRENT_LIMIT = 18'd196608;
	localparam logic [17:0] RST_ALIGN_CURRENT = 18'd117965;
	localparam logic [15:0] RST_ALIGN_STEP    = 16'd922;
	localparam logic [7:0]  RST_HOLD_TICKS    = 8'd128;
	localparam logic [15:0] RST_SPEED_SLEW    = 16'd128;
	localparam logic [15:0] RST_OFFSET_COUNT  = 16'd1024;

	localparam logic [17:0] D_MAX    = 18'h3FFFF;
	localparam logic [8:0]  HOLD_MAX = 9'h1FF;

	// phase codes as shown on drive_phase
	localparam logic [3:0] CODE_STANDBY = 4'd0;
	localparam logic [3:0] CODE_CALIB   = 4'd1;
	localparam logic [3:0] CODE_RAMP1   = 4'd2;
	localparam logic [3:0] CODE_HOLD1   = 4'd3;
	localparam logic [3:0] CODE_RAMP2   = 4'd4;
	localparam logic [3:0] CODE_HOLD2   = 4'd5;
	localparam logic [3:0] CODE_WAIT    = 4'd6;
	localparam logic [3:0] CODE_DRIVE   = 4'd7;
	localparam logic [3:0] CODE_BRAKE   = 4'd8;

	typedef enum logic [8:0] {
		PH_STANDBY = 9'b000000001,
		PH_CALIB   = 9'b000000010,
		PH_RAMP1   = 9'b000000100,
		PH_HOLD1   = 9'b000001000,
		PH_RAMP2   = 9'b000010000,
		PH_HOLD2   = 9'b000100000,
		PH_WAIT    = 9'b001000000,
		PH_DRIVE   = 9'b010000000,
		PH_BRAKE   = 9'b100000000
	} phase_t;

	function automatic logic [3:0] phase_code(input phase_t ph);
		logic [3:0] c;
		case (ph)
			PH_CALIB: c = CODE_CALIB;
			PH_RAMP1: c = CODE_RAMP1;
			PH_HOLD1: c = CODE_HOLD1;
			PH_RAMP2: c = CODE_RAMP2;
			PH_HOLD2: c = CODE_HOLD2;
			PH_WAIT:  c = CODE_WAIT;
			PH_DRIVE: c = CODE_DRIVE;
			PH_BRAKE: c = CODE_BRAKE;
			default:  c = CODE_STANDBY;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/bldc_startup_speed_controller_unit.sv
// BLDC start-up sequencer with saturating PI speed loop, one item per control tick.
// Depends on bssc_pkg (phase type, register indexes, reset values).
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | calib_count, start/stop_request, speeds
//  result   | out_valid/ out_ready | drive_phase, d/q current refs, speed ref,
//           |                      | peak_speed, three event pulses
//  config   | wr_en                | wr_index (3b), wr_data (18b), no read-back
//
// One item per clock sustained while out_ready stays high; a result is shown once
// its item has passed the input register and then the state/result registers.
// The critical path is slew, error, one 17x21 multiply, add and two clamps.
// Reset puts the sequencer in standby with all loop state cleared and the
// registers at their documented defaults.
// A stalled result holds; the input register still takes one more item.
module bldc_startup_speed_controller_unit
	import bssc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        calib_count,
	input  logic               start_request,
	input  logic               stop_request,
	input  logic signed [19:0] target_speed,
	input  logic signed [19:0] measured_speed,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         drive_phase,
	output logic signed [18:0] d_current_ref,
	output logic signed [18:0] q_current_ref,
	output logic signed [19:0] speed_reference,
	output logic signed [19:0] peak_speed,
	output logic               pwm_reset_pulse,
	output logic               drive_enable_pulse,
	output logic               encoder_zero_pulse
);

	// ---------------- configuration registers ----------------
	logic [15:0] prop_gain_q, integ_gain_q, align_step_q, speed_slew_q, offset_count_q;
	logic [17:0] current_limit_q, align_current_q;
	logic [7:0]  hold_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= RST_PROP_GAIN;
			integ_gain_q    <= RST_INTEG_GAIN;
			current_limit_q <= RST_CURRENT_LIMIT;
			align_current_q <= RST_ALIGN_CURRENT;
			align_step_q    <= RST_ALIGN_STEP;
			hold_ticks_q    <= RST_HOLD_TICKS;
			speed_slew_q    <= RST_SPEED_SLEW;
			offset_count_q  <= RST_OFFSET_COUNT;
		end else if (wr_en) begin
			case (wr_index)
				REG_PROP_GAIN:     prop_gain_q     <= wr_data[15:0];
				REG_INTEG_GAIN:    integ_gain_q    <= wr_data[15:0];
				REG_CURRENT_LIMIT: current_limit_q <= wr_data[17:0];
				REG_ALIGN_CURRENT: align_current_q <= wr_data[17:0];
				REG_ALIGN_STEP:    align_step_q    <= wr_data[15:0];
				REG_HOLD_TICKS:    hold_ticks_q    <= wr_data[7:0];
				REG_SPEED_SLEW:    speed_slew_q    <= wr_data[15:0];
				REG_OFFSET_COUNT:  offset_count_q  <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic valid_s1, out_valid_q, adv;

	// the item in the input register moves on when the result slot is free
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ---------------- input register ----------------
	logic [15:0]        calib_s1;
	logic               start_s1, stop_s1;
	logic signed [19:0] target_s1, meas_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			calib_s1  <= calib_count;
			start_s1  <= start_request;
			stop_s1   <= stop_request;
			target_s1 <= target_speed;
			meas_s1   <= measured_speed;
		end
	end

	// ---------------- sequencer and loop state ----------------
	// These registers change only when an item advances, so they double
	// as the result payload while out_valid waits for out_ready.
	phase_t             phase_q, phase_nx;
	logic [17:0]        d_cur_q, d_cur_nx;
	logic signed [18:0] q_cur_q, q_cur_nx;
	logic signed [18:0] integ_q, integ_nx;
	logic signed [19:0] ref_q, ref_nx;
	logic signed [19:0] peak_q, peak_nx;
	logic [8:0]         hold_q, hold_nx;
	logic [1:0]         wait_q, wait_nx;
	logic               pwm_q, en_q, enc_q;
	logic               pwm_nx, en_nx, enc_nx;

	// saturate to +/- limit (limit is at most 18 bits)
	function automatic logic signed [18:0] clamp_lim(input logic signed [22:0] v,
			input logic [17:0] lim);
		logic signed [22:0] l;
		l = $signed({5'd0, lim});
		if (v > l) return l[18:0];
		if (v < -l) return -l[18:0];
		return v[18:0];
	endfunction

	// reference slew for drive and brake
	logic signed [21:0] ref_w, slew_w, tgt_w, up_w, dn_w, drive_ref_w, brake_ref_w;
	logic signed [19:0] pi_ref;

	always_comb begin
		ref_w  = 22'(ref_q);
		slew_w = $signed({6'd0, speed_slew_q});
		tgt_w  = 22'(target_s1);
		up_w   = ref_w + slew_w;
		dn_w   = ref_w - slew_w;
		if (tgt_w > ref_w)      drive_ref_w = (up_w > tgt_w) ? tgt_w : up_w;
		else if (tgt_w < ref_w) drive_ref_w = (dn_w < tgt_w) ? tgt_w : dn_w;
		else                    drive_ref_w = ref_w;
		// brake never goes below zero, a negative reference clamps at once
		brake_ref_w = dn_w[21] ? 22'sd0 : dn_w;
		pi_ref = (phase_q == PH_BRAKE) ? brake_ref_w[19:0] : drive_ref_w[19:0];
	end

	// PI: gain*error in Q.32, round half up, back to Q.16
	logic signed [20:0] err;
	logic signed [37:0] p_prod, i_prod;
	logic signed [21:0] p_term, i_inc;
	logic signed [22:0] i_sum, pq_sum;
	logic signed [18:0] integ_pi, q_pi;

	always_comb begin
		err      = 21'(pi_ref) - 21'(meas_s1);
		p_prod   = 38'($signed({1'b0, prop_gain_q})) * 38'(err) + 38'sd32768;
		i_prod   = 38'($signed({1'b0, integ_gain_q})) * 38'(err) + 38'sd32768;
		p_term   = p_prod[37:16];
		i_inc    = i_prod[37:16];
		i_sum    = 23'(integ_q) + 23'(i_inc);
		integ_pi = clamp_lim(i_sum, current_limit_q);
		pq_sum   = 23'(p_term) + 23'(integ_pi);
		q_pi     = clamp_lim(pq_sum, current_limit_q);
	end

	// alignment ramp and hold
	logic        ramp_end, hold_end;
	logic [18:0] d_add;
	logic [17:0] d_step;
	logic [8:0]  hold_inc;

	always_comb begin
		ramp_end = (d_cur_q > align_current_q) || (d_cur_q == D_MAX);
		d_add    = {1'b0, d_cur_q} + {3'd0, align_step_q};
		d_step   = d_add[18] ? D_MAX : d_add[17:0];
		hold_end = hold_q > {1'b0, hold_ticks_q};
		hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 9'd1;
	end

	always_comb begin
		phase_nx = phase_q;
		d_cur_nx = d_cur_q;
		q_cur_nx = q_cur_q;
		integ_nx = integ_q;
		ref_nx   = ref_q;
		peak_nx  = peak_q;
		hold_nx  = hold_q;
		wait_nx  = wait_q;
		pwm_nx   = 1'b0;
		en_nx    = 1'b0;
		enc_nx   = 1'b0;
		case (phase_q)
			PH_CALIB: begin
				if (calib_s1 >= offset_count_q && start_s1) begin
					phase_nx = PH_RAMP1;
					en_nx    = 1'b1;
				end
			end
			PH_RAMP1, PH_RAMP2: begin
				if (ramp_end) begin
					hold_nx  = '0;
					phase_nx = (phase_q == PH_RAMP1) ? PH_HOLD1 : PH_HOLD2;
				end else begin
					d_cur_nx = d_step;
				end
			end
			PH_HOLD1: begin
				if (hold_end) begin
					enc_nx   = 1'b1;
					d_cur_nx = '0;
					phase_nx = PH_RAMP2;
				end else begin
					hold_nx = hold_inc;
				end
			end
			PH_HOLD2: begin
				if (hold_end) begin
					d_cur_nx = '0;
					ref_nx   = '0;
					wait_nx  = '0;
					phase_nx = PH_WAIT;
				end else begin
					hold_nx = hold_inc;
				end
			end
			PH_WAIT: begin
				if (wait_q > 2'd1) phase_nx = PH_DRIVE;
				if (wait_q != 2'd3) wait_nx = wait_q + 2'd1;
			end
			PH_DRIVE: begin
				ref_nx   = pi_ref;
				if (peak_q < meas_s1) peak_nx = meas_s1;
				integ_nx = integ_pi;
				q_cur_nx = q_pi;
				if (stop_s1) phase_nx = PH_BRAKE;
			end
			PH_BRAKE: begin
				ref_nx   = pi_ref;
				integ_nx = integ_pi;
				q_cur_nx = q_pi;
				// start wins over stop here and restarts the slew from zero
				if (start_s1) begin
					ref_nx   = '0;
					phase_nx = PH_DRIVE;
				end
			end
			default: begin
				// standby: clear loop state, reset PWM; ref is left alone
				d_cur_nx = '0;
				q_cur_nx = '0;
				integ_nx = '0;
				peak_nx  = '0;
				pwm_nx   = 1'b1;
				phase_nx = PH_CALIB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STANDBY;
			d_cur_q <= '0;
			q_cur_q <= '0;
			integ_q <= '0;
			ref_q   <= '0;
			peak_q  <= '0;
			hold_q  <= '0;
			wait_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_nx;
			d_cur_q <= d_cur_nx;
			q_cur_q <= q_cur_nx;
			integ_q <= integ_nx;
			ref_q   <= ref_nx;
			peak_q  <= peak_nx;
			hold_q  <= hold_nx;
			wait_q  <= wait_nx;
		end
	end

	// event pulses belong to the result item only
	always_ff @(posedge clk) begin
		if (adv) begin
			pwm_q <= pwm_nx;
			en_q  <= en_nx;
			enc_q <= enc_nx;
		end
	end

	// ---------------- result ----------------
	assign out_valid          = out_valid_q;
	assign drive_phase        = phase_code(phase_q);
	assign d_current_ref      = $signed({1'b0, d_cur_q});
	assign q_current_ref      = q_cur_q;
	assign speed_reference    = ref_q;
	assign peak_speed         = peak_q;
	assign pwm_reset_pulse    = pwm_q;
	assign drive_enable_pulse = en_q;
	assign encoder_zero_pulse = enc_q;

endmodule

// File: hw/rtl/bssc_checker.sv
// bssc_checker: port-level checks of the start-up / speed controller.
// Depends on bssc_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module bssc_checker
	import bssc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               wr_en,
	input logic [2:0]         wr_index,
	input logic [CFG_DATA_W-1:0] wr_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic [15:0]        calib_count,
	input logic               start_request,
	input logic               stop_request,
	input logic signed [19:0] target_speed,
	input logic signed [19:0] measured_speed,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         drive_phase,
	input logic signed [18:0] d_current_ref,
	input logic signed [18:0] q_current_ref,
	input logic signed [19:0] speed_reference,
	input logic signed [19:0] peak_speed,
	input logic               pwm_reset_pulse,
	input logic               drive_enable_pulse,
	input logic               encoder_zero_pulse
);

	// a stalled result keeps its phase and currents
	`ASSERT_CLK(a_stall_holds, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(drive_phase) && $stable(q_current_ref) && $stable(d_current_ref))

	// standby tick lands in calib wait with the loop cleared
	`ASSERT_ON_OUT(a_pwm_reset, clk, arst_n, out_valid && pwm_reset_pulse, drive_phase == CODE_CALIB && d_current_ref == 19'sd0 && q_current_ref == 19'sd0 && peak_speed == 20'sd0)

	// drive enable only on entry to the first ramp, d still at zero
	`ASSERT_ON_OUT(a_drive_en, clk, arst_n, out_valid && drive_enable_pulse, drive_phase == CODE_RAMP1 && d_current_ref == 19'sd0)

	// encoder zero only on entry to the second ramp with d cleared
	`ASSERT_ON_OUT(a_enc_zero, clk, arst_n, out_valid && encoder_zero_pulse, drive_phase == CODE_RAMP2 && d_current_ref == 19'sd0)

	// at most one event per result, and d current never negative
	`ASSERT_ON_OUT(a_events, clk, arst_n, out_valid, $onehot0({pwm_reset_pulse, drive_enable_pulse, encoder_zero_pulse}) && !d_current_ref[18])

endmodule

bind bldc_startup_speed_controller_unit bssc_checker u_bssc_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for bldc_startup_speed_controller_unit.
// Drives control ticks through the start-up sequence, then random drive/brake traffic.
// Needs bssc_pkg and the unit RTL only.
module tb_top;
	import bssc_pkg::*;

	// one control tick as sent on the input channel
	typedef struct {
		logic [15:0]        calib;
		logic               start;
		logic               stop;
		logic signed [19:0] target;
		logic signed [19:0] meas;
	} tick_in_t;

	// one result item as seen on the output channel
	typedef struct {
		logic [3:0]         phase;
		logic signed [18:0] d;
		logic signed [18:0] q;
		logic signed [19:0] sref;
		logic signed [19:0] peak;
		logic               pwm;
		logic               en;
		logic               enc;
	} tick_out_t;

	// shadow copy of the register file
	typedef struct {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [17:0] current_limit;
		logic [17:0] align_current;
		logic [15:0] align_step;
		logic [7:0]  hold_ticks;
		logic [15:0] speed_slew;
		logic [15:0] offset_count;
	} ctrl_cfg_t;

	localparam longint D_CEIL   = longint'(D_MAX);
	localparam longint HOLD_TOP = longint'(HOLD_MAX);

	// DUT signals, every input known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [2:0]            wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [15:0]           calib_count = '0;
	logic                  start_request = 1'b0;
	logic                  stop_request = 1'b0;
	logic signed [19:0]    target_speed = '0;
	logic signed [19:0]    measured_speed = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [3:0]            drive_phase;
	logic signed [18:0]    d_current_ref;
	logic signed [18:0]    q_current_ref;
	logic signed [19:0]    speed_reference;
	logic signed [19:0]    peak_speed;
	logic                  pwm_reset_pulse;
	logic                  drive_enable_pulse;
	logic                  encoder_zero_pulse;

	// predictor state, updated as each item is accepted
	ctrl_cfg_t   cfg;
	logic [3:0]  seq_phase;
	longint      d_amps, q_amps, integ_acc, ref_spd, peak_spd;
	longint      hold_cnt, wait_cnt;

	tick_out_t   tick_results[$];   // results owed by the block, oldest first
	int          errors = 0;
	bit          no_idle = 1'b0;    // burst stretches: no gaps on either side
	int unsigned ready_stall = 0;
	longint      goal_spd = 0;      // slowly moving speed command for random drive

	bldc_startup_speed_controller_unit i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.calib_count        (calib_count),
		.start_request      (start_request),
		.stop_request       (stop_request),
		.target_speed       (target_speed),
		.measured_speed     (measured_speed),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.drive_phase        (drive_phase),
		.d_current_ref      (d_current_ref),
		.q_current_ref      (q_current_ref),
		.speed_reference    (speed_reference),
		.peak_speed         (peak_speed),
		.pwm_reset_pulse    (pwm_reset_pulse),
		.drive_enable_pulse (drive_enable_pulse),
		.encoder_zero_pulse (encoder_zero_pulse)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// saturating PI step; products are Q.32, rounded half up back to Q.16
	function automatic void pi_update(input longint meas);
		longint err, lim, p, inc;
		err = ref_spd - meas;
		lim = longint'(cfg.current_limit);
		p = (longint'(cfg.prop_gain) * err + 32768) >>> 16;
		inc = (longint'(cfg.integ_gain) * err + 32768) >>> 16;
		integ_acc = clamp_sym(integ_acc + inc, lim);
		q_amps = clamp_sym(p + integ_acc, lim);
	endfunction

	// one ramp tick; ends once d is past the target or pinned at the ceiling
	function automatic bit ramp_done();
		if (d_amps > longint'(cfg.align_current) || d_amps >= D_CEIL) begin
			hold_cnt = 0;
			return 1'b1;
		end
		d_amps = d_amps + longint'(cfg.align_step);
		if (d_amps > D_CEIL)
			d_amps = D_CEIL;
		return 1'b0;
	endfunction

	function automatic bit hold_done();
		if (hold_cnt > longint'(cfg.hold_ticks))
			return 1'b1;
		if (hold_cnt < HOLD_TOP)
			hold_cnt++;
		return 1'b0;
	endfunction

	// advances the shadow sequencer by one tick and returns the result it owes
	function automatic tick_out_t predict_tick(input tick_in_t it);
		tick_out_t res;
		longint    tgt, meas, r, slew;
		logic      pwm, en, enc;
		tgt = longint'(it.target);
		meas = longint'(it.meas);
		slew = longint'(cfg.speed_slew);
		pwm = 1'b0;
		en = 1'b0;
		enc = 1'b0;
		case (seq_phase)
			CODE_CALIB: begin
				if (it.calib >= cfg.offset_count && it.start) begin
					seq_phase = CODE_RAMP1;
					en = 1'b1;
				end
			end
			CODE_RAMP1: begin
				if (ramp_done())
					seq_phase = CODE_HOLD1;
			end
			CODE_HOLD1: begin
				if (hold_done()) begin
					enc = 1'b1;
					d_amps = 0;
					seq_phase = CODE_RAMP2;
				end
			end
			CODE_RAMP2: begin
				if (ramp_done())
					seq_phase = CODE_HOLD2;
			end
			CODE_HOLD2: begin
				if (hold_done()) begin
					d_amps = 0;
					ref_spd = 0;
					wait_cnt = 0;
					seq_phase = CODE_WAIT;
				end
			end
			CODE_WAIT: begin
				if (wait_cnt > 1)
					seq_phase = CODE_DRIVE;
				if (wait_cnt < 3)
					wait_cnt++;
			end
			CODE_DRIVE: begin
				r = ref_spd;
				if (tgt > r) begin
					r = r + slew;
					if (r > tgt)
						r = tgt;
				end else if (tgt < r) begin
					r = r - slew;
					if (r < tgt)
						r = tgt;
				end
				ref_spd = r;
				if (peak_spd < meas)
					peak_spd = meas;
				pi_update(meas);
				if (it.stop)
					seq_phase = CODE_BRAKE;
			end
			CODE_BRAKE: begin
				r = ref_spd - slew;
				if (r < 0)
					r = 0;
				ref_spd = r;
				pi_update(meas);
				// start wins over stop while braking
				if (it.start) begin
					ref_spd = 0;
					seq_phase = CODE_DRIVE;
				end
			end
			default: begin
				// standby: clear the loop, keep ref_spd, pulse the PWM reset
				d_amps = 0;
				q_amps = 0;
				integ_acc = 0;
				peak_spd = 0;
				pwm = 1'b1;
				seq_phase = CODE_CALIB;
			end
		endcase
		res.phase = seq_phase;
		res.d = d_amps[18:0];
		res.q = q_amps[18:0];
		res.sref = ref_spd[19:0];
		res.peak = peak_spd[19:0];
		res.pwm = pwm;
		res.en = en;
		res.enc = enc;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [17:0] pick_val(input int unsigned w);
		logic [17:0] mask;
		mask = 18'((1 << w) - 1);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return mask;
			default: return 18'($urandom) & mask;
		endcase
	endfunction

	function automatic tick_in_t mk_item(input int unsigned calib, input bit start,
			input bit stop, input int target, input int meas);
		tick_in_t it;
		it.calib = 16'(calib);
		it.start = start;
		it.stop = stop;
		it.target = 20'(target);
		it.meas = 20'(meas);
		return it;
	endfunction

	// random tick shaped by the predicted phase: long drive stretches,
	// brake now and then, speeds mostly near the command with some wild ones
	function automatic tick_in_t drive_item();
		tick_in_t    it;
		int unsigned r;
		it.calib = 16'($urandom);
		r = $urandom_range(0, 99);
		if (seq_phase == CODE_BRAKE) begin
			it.start = (r < 20);
			it.stop = 1'($urandom);
		end else begin
			it.stop = (r < 6);
			it.start = 1'($urandom);
		end
		if ($urandom_range(0, 19) == 0)
			goal_spd = longint'($urandom_range(0, 60000)) - 30000;
		if ($urandom_range(0, 9) < 3)
			it.target = 20'($urandom);
		else
			it.target = 20'(goal_spd);
		if ($urandom_range(0, 3) == 0)
			it.meas = 20'($urandom);
		else
			it.meas = 20'(ref_spd + longint'($urandom_range(0, 4000)) - 2000);
		return it;
	endfunction

	// one item: optional gap, hold valid until taken, then book its result
	task automatic send_tick(input tick_in_t it);
		int unsigned gap;
		gap = idle_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		calib_count <= it.calib;
		start_request <= it.start;
		stop_request <= it.stop;
		target_speed <= it.target;
		measured_speed <= it.meas;
		do @(posedge clk); while (!in_ready);
		tick_results.push_back(predict_tick(it));
	endtask

	// idle the input side and let every owed result drain out of the pipe
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tick_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// writes the whole register file; only called with the block idle
	task automatic apply_config(input ctrl_cfg_t c);
		write_reg(REG_PROP_GAIN, CFG_DATA_W'(c.prop_gain));
		write_reg(REG_INTEG_GAIN, CFG_DATA_W'(c.integ_gain));
		write_reg(REG_CURRENT_LIMIT, c.current_limit);
		write_reg(REG_ALIGN_CURRENT, c.align_current);
		write_reg(REG_ALIGN_STEP, CFG_DATA_W'(c.align_step));
		write_reg(REG_HOLD_TICKS, CFG_DATA_W'(c.hold_ticks));
		write_reg(REG_SPEED_SLEW, CFG_DATA_W'(c.speed_slew));
		write_reg(REG_OFFSET_COUNT, CFG_DATA_W'(c.offset_count));
		@(negedge clk);
		wr_en <= 1'b0;
		cfg = c;
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [19:0] want,
			input logic [19:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		tick_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tick_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item, phase %0d", $time, drive_phase);
			end else begin
				want = tick_results.pop_front();
				check_field("drive_phase", 20'(want.phase), 20'(drive_phase));
				check_field("d_current_ref", 20'(want.d), 20'(d_current_ref));
				check_field("q_current_ref", 20'(want.q), 20'(q_current_ref));
				check_field("speed_reference", want.sref, speed_reference);
				check_field("peak_speed", want.peak, peak_speed);
				check_field("pwm_reset_pulse", 20'(want.pwm), 20'(pwm_reset_pulse));
				check_field("drive_enable_pulse", 20'(want.en), 20'(drive_enable_pulse));
				check_field("encoder_zero_pulse", 20'(want.enc), 20'(encoder_zero_pulse));
			end
		end
	end

	// result side back-pressure: random stalls, none in burst stretches
	always @(negedge clk) begin
		if (ready_stall != 0) begin
			out_ready <= 1'b0;
			ready_stall--;
		end else begin
			out_ready <= 1'b1;
			ready_stall = idle_len();
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// standby tick, then the calibration gate at reset count, zero and full count
	task automatic test_standby_calib();
		ctrl_cfg_t c;
		send_tick(mk_item(0, 1'b0, 1'b0, 0, 0));             // standby, PWM reset
		send_tick(mk_item(1023, 1'b1, 1'b0, 1000, -1000));   // one sample short
		send_tick(mk_item(1024, 1'b0, 1'b1, -1, 1));         // enough, no start
		settle();
		c = cfg;
		c.offset_count = '0;
		apply_config(c);
		send_tick(mk_item(0, 1'b0, 1'b0, 524287, -524288));  // zero count, no start
		settle();
		c.offset_count = 16'hFFFF;
		apply_config(c);
		send_tick(mk_item(65534, 1'b1, 1'b1, 0, 0));         // one short of full count
		send_tick(mk_item(65535, 1'b1, 1'b0, 0, 0));         // go: drive enable pulse
	endtask

	// both ramps and holds: stuck ramp, ceiling saturation, zero hold, longest hold
	task automatic test_align_sequence();
		ctrl_cfg_t c;
		settle();
		c = cfg;
		c.align_step = '0;                                   // d never grows
		apply_config(c);
		repeat (3) send_tick(drive_item());
		settle();
		c.align_step = 16'hFFFF;
		c.align_current = 18'h3FFFF;                         // only the ceiling ends it
		c.hold_ticks = '0;
		apply_config(c);
		while (seq_phase != CODE_HOLD1)
			send_tick(drive_item());
		while (seq_phase != CODE_RAMP2)
			send_tick(drive_item());
		settle();
		c.align_current = '0;
		c.align_step = 16'd1;
		c.hold_ticks = 8'hFF;
		apply_config(c);
		while (seq_phase != CODE_DRIVE)
			send_tick(drive_item());
	endtask

	// saturation, negative reference into brake, request priority, zero gains, rounding
	task automatic test_drive_extremes();
		ctrl_cfg_t c;
		settle();
		c = cfg;
		c.prop_gain = 16'hFFFF;
		c.integ_gain = 16'hFFFF;
		c.current_limit = 18'h3FFFF;
		c.speed_slew = 16'hFFFF;
		apply_config(c);
		send_tick(mk_item(0, 1'b0, 1'b0, 524287, -524288));
		send_tick(mk_item(0, 1'b0, 1'b0, 524287, 524287));
		repeat (4) send_tick(mk_item(0, 1'b0, 1'b0, -524288, 0));
		send_tick(mk_item(0, 1'b0, 1'b1, -524288, -300));    // stop with reference below zero
		send_tick(mk_item(0, 1'b0, 1'b0, 0, 100));           // first brake tick clamps to zero
		send_tick(mk_item(0, 1'b0, 1'b1, 0, 0));
		send_tick(mk_item(0, 1'b1, 1'b1, 0, 0));             // brake: start wins
		send_tick(mk_item(0, 1'b1, 1'b1, 0, 0));             // drive: stop acted on
		send_tick(mk_item(0, 1'b1, 1'b0, 0, 0));
		settle();
		c.prop_gain = '0;
		c.integ_gain = '0;
		c.current_limit = '0;
		c.speed_slew = '0;
		apply_config(c);
		send_tick(mk_item(65535, 1'b0, 1'b0, 524287, -524288));
		send_tick(mk_item(0, 1'b1, 1'b0, -524288, 524287));
		settle();
		// half-gain: errors of odd size land exactly on the rounding midpoint
		c.prop_gain = 16'd32768;
		c.integ_gain = 16'd32768;
		c.current_limit = 18'h3FFFF;
		apply_config(c);
		send_tick(mk_item(0, 1'b0, 1'b0, 0, 1));
		send_tick(mk_item(0, 1'b0, 1'b0, 0, -1));
		send_tick(mk_item(0, 1'b0, 1'b0, 0, 3));
		send_tick(mk_item(0, 1'b0, 1'b0, 0, -3));
	endtask

	// random drive/brake traffic under a fresh register setting per phase
	task automatic test_random_drive();
		ctrl_cfg_t c;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			c.prop_gain = 16'(pick_val(16));
			c.integ_gain = 16'(pick_val(16));
			c.current_limit = pick_val(18);
			c.align_current = pick_val(18);
			c.align_step = 16'(pick_val(16));
			c.hold_ticks = 8'(pick_val(8));
			c.speed_slew = 16'(pick_val(16));
			c.offset_count = 16'(pick_val(16));
			apply_config(c);
			no_idle = (ph % 3 == 2);
			repeat (110) send_tick(drive_item());
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		cfg = '{prop_gain: RST_PROP_GAIN, integ_gain: RST_INTEG_GAIN,
			current_limit: RST_CURRENT_LIMIT, align_current: RST_ALIGN_CURRENT,
			align_step: RST_ALIGN_STEP, hold_ticks: RST_HOLD_TICKS,
			speed_slew: RST_SPEED_SLEW, offset_count: RST_OFFSET_COUNT};
		seq_phase = CODE_STANDBY;
		d_amps = 0;
		q_amps = 0;
		integ_acc = 0;
		ref_spd = 0;
		peak_spd = 0;
		hold_cnt = 0;
		wait_cnt = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_standby_calib();
		test_align_sequence();
		test_drive_extremes();
		test_random_drive();
		settle();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

endmodule
